### hdl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared types and constants for the TLB translation block
// Holds the field widths, configuration register map, sequencer states and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbpt_pkg;

    // Fixed field widths of the channels and of the frame limit.
    localparam int VA_W    = 16;
    localparam int PA_W    = 16;
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 9;

    // Default geometry, handed to the top-level parameters.
    localparam int DEF_TLB_ENTRIES = 16;
    localparam int DEF_PAGES       = 256;
    localparam int DEF_FRAMES      = 256;
    localparam int DEF_PAGE_BYTES  = 256;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] CFG_FRAME_LIMIT_ADDR = 3'd0;
    localparam logic [LIMIT_W-1:0]    FRAME_LIMIT_RESET    = 9'd256;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_RESOLVE,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic lookup;
        logic resolve;
        logic push;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tlb_hit;
        logic out_free;
    } t_status;

    // One result word.
    typedef struct packed {
        logic [PA_W-1:0]   physical_address;
        logic [BYTE_W-1:0] frame_number;
        logic              tlb_hit;
        logic              page_fault;
        logic [BYTE_W-1:0] fetch_page;
        logic              evict_valid;
        logic [BYTE_W-1:0] evicted_page;
    } t_result;

endpackage

`default_nettype wire

### hdl/tlbpt_va_if.sv
// ----------------------------------------------------------------------------
// tlbpt_va_if: virtual address channel
// Valid/ready channel that carries one virtual address per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlbpt_va_if import tlbpt_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [VA_W-1:0] virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink   (input valid, input virtual_address, output ready);

endinterface

`default_nettype wire

### hdl/tlbpt_res_if.sv
// ----------------------------------------------------------------------------
// tlbpt_res_if: translation result channel
// Valid/ready channel that carries one translation result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlbpt_res_if import tlbpt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [PA_W-1:0]   physical_address;
    logic [BYTE_W-1:0] frame_number;
    logic              tlb_hit;
    logic              page_fault;
    logic [BYTE_W-1:0] fetch_page;
    logic              evict_valid;
    logic [BYTE_W-1:0] evicted_page;

    modport source (
        output valid, output physical_address, output frame_number, output tlb_hit,
        output page_fault, output fetch_page, output evict_valid, output evicted_page,
        input  ready
    );
    modport sink (
        input  valid, input physical_address, input frame_number, input tlb_hit,
        input  page_fault, input fetch_page, input evict_valid, input evicted_page,
        output ready
    );

endinterface

`default_nettype wire

### hdl/tlb_page_table_fifo_translate.sv
// ----------------------------------------------------------------------------
// tlb_page_table_fifo_translate: virtual to physical address translation
// A TLB with round-robin refill in front of a demand-paged page table with
// FIFO frame reclaim.
// ----------------------------------------------------------------------------
// Usage:
//   i_va carries one virtual address per word; the upper bits select the
//   page, the lower bits are the offset. o_res returns one result word per
//   address: physical address, frame, hit and fault flags, the page to fetch
//   and the evicted page, if any. The user is to write frame_limit over the
//   APB-style port only while the block is idle; this is not enforced.
// Timing:
//   Addresses are handled one at a time by the sequencer. On a TLB hit the
//   lookup result goes straight to the output hand-off; a miss adds a
//   resolve step, which uses the registered read of the page table and
//   frame owner memories. A new address is accepted only after the result
//   has been handed to the output register.
// Reset and stall:
//   Reset clears the TLB and page table valid bits, the frame fill count
//   and the allocator, and sets frame_limit to 256. When the receiver
//   stalls, the result waits in the output register and the sequencer
//   holds the following result until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_fifo_translate import tlbpt_pkg::*; #(
    parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
    parameter int PAGES       = DEF_PAGES,
    parameter int FRAMES      = DEF_FRAMES,
    parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tlbpt_va_if.sink                   i_va,
    tlbpt_res_if.source                o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [LIMIT_W-1:0] frame_limit;
    t_cmd               cmd;
    t_status            status;
    logic               in_ready;
    logic               out_valid;
    t_result            out_word;

    // Configuration registers.
    tlbpt_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_frame_limit (frame_limit)
    );

    // Sequencer.
    tlbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_va.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath.
    tlbpt_dp #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGES       (PAGES),
        .FRAMES      (FRAMES),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_va          (i_va.virtual_address),
        .i_frame_limit (frame_limit),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (out_valid),
        .o_out         (out_word)
    );

    // Channel connections.
    assign i_va.ready             = in_ready;
    assign o_res.valid            = out_valid;
    assign o_res.physical_address = out_word.physical_address;
    assign o_res.frame_number     = out_word.frame_number;
    assign o_res.tlb_hit          = out_word.tlb_hit;
    assign o_res.page_fault       = out_word.page_fault;
    assign o_res.fetch_page       = out_word.fetch_page;
    assign o_res.evict_valid      = out_word.evict_valid;
    assign o_res.evicted_page     = out_word.evicted_page;

endmodule

`default_nettype wire

### hdl/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// tlbpt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/tlbpt_cfg.sv
// ----------------------------------------------------------------------------
// tlbpt_cfg: configuration register file
// APB-style slave holding the frame limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_cfg import tlbpt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [LIMIT_W-1:0]    o_frame_limit
);

    logic [LIMIT_W-1:0] r_frame_limit;
    logic               wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == CFG_FRAME_LIMIT_ADDR);

    // Frame limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= FRAME_LIMIT_RESET;
        end else if (wr_en) begin
            r_frame_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb begin
        if (paddr == CFG_FRAME_LIMIT_ADDR) begin
            prdata = APB_DATA_W'(r_frame_limit);
        end else begin
            prdata = '0;
        end
    end

    assign o_frame_limit = r_frame_limit;

endmodule

`default_nettype wire

### hdl/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpt_ctrl: translation sequencer
// Each address: lookup, page table resolve on a TLB miss, output hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_ctrl import tlbpt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // No word is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = i_status.tlb_hit ? S_DONE : S_RESOLVE;
            end
            S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // Wait until the output register can take the word.
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/tlbpt_dp.sv
// ----------------------------------------------------------------------------
// tlbpt_dp: translation datapath
// TLB registers, page table and frame owner memories, FIFO frame allocator
// and the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_dp import tlbpt_pkg::*; #(
    parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
    parameter int PAGES       = DEF_PAGES,
    parameter int FRAMES      = DEF_FRAMES,
    parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic [VA_W-1:0]    i_va,
    input  wire logic [LIMIT_W-1:0] i_frame_limit,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output t_result                 o_out
);

    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int PAGE_W  = $clog2(PAGES);
    localparam int FRAME_W = $clog2(FRAMES);
    localparam int SLOT_W  = $clog2(TLB_ENTRIES);
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TLB_ENTRIES - 1);

    // Current request.
    logic [PAGE_W-1:0]  r_page;
    logic [OFF_W-1:0]   r_off;

    // TLB.
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [PAGE_W-1:0]      r_tlb_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_tlb_frame [TLB_ENTRIES];
    logic [SLOT_W-1:0]      r_tlb_next;

    // Page table valid bits, frame fill count and the allocator.
    // Frames are taken in order starting at frame zero, so a frame has an
    // owner exactly when it lies below the fill count.
    logic [PAGES-1:0]   r_page_valid;
    logic [CNT_W-1:0]   r_fill;
    logic [FRAME_W-1:0] r_next_frame;
    logic               r_frames_full;

    // Values carried from lookup to resolve.
    logic               r_pv;
    logic [FRAME_W-1:0] r_fault_fr;
    logic               r_wrap;

    // Result and output registers.
    t_result r_res;
    t_result r_out;
    logic    r_out_valid;

    // Combinational signals.
    logic               hit;
    logic [FRAME_W-1:0] hit_fr;
    logic [CNT_W-1:0]   lim;
    logic               wrap1;
    logic [FRAME_W-1:0] ffr;
    logic [FRAME_W-1:0] pf_rdata;
    logic [PAGE_W-1:0]  victim;
    logic               full_now;
    logic               evict;
    logic [FRAME_W-1:0] res_fr;
    logic [CNT_W-1:0]   nf2;
    logic               wrap2;
    logic               tbl_we;
    t_result            hit_res;
    t_result            miss_res;

    // TLB search; the lowest matching slot wins.
    always_comb begin
        hit    = 1'b0;
        hit_fr = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (r_tlb_page[i] == r_page)) begin
                hit    = 1'b1;
                hit_fr = r_tlb_frame[i];
            end
        end
    end

    // Usable frame count: a limit of zero acts as one, above the pool as the pool.
    always_comb begin
        if (i_frame_limit == '0) begin
            lim = CNT_W'(1);
        end else if (32'(i_frame_limit) > FRAMES) begin
            lim = CNT_W'(FRAMES);
        end else begin
            lim = CNT_W'(i_frame_limit);
        end
    end

    // Frame to take on a fault, with wrap when the pointer passed the limit.
    assign wrap1 = (CNT_W'(r_next_frame) >= lim);
    assign ffr   = wrap1 ? '0 : r_next_frame;

    // Resolve step: eviction, chosen frame and allocator advance.
    assign full_now = r_frames_full || r_wrap;
    assign evict    = !r_pv && full_now && (CNT_W'(r_fault_fr) < r_fill);
    assign res_fr   = r_pv ? pf_rdata : r_fault_fr;
    assign nf2      = CNT_W'(r_fault_fr) + CNT_W'(1);
    assign wrap2    = (nf2 >= lim);
    assign tbl_we   = i_cmd.resolve && !r_pv;

    // Page table frame store, indexed by page.
    tlbpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PAGES)
    ) u_page_frame (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_page),
        .i_wdata (r_fault_fr),
        .i_raddr (r_page),
        .o_rdata (pf_rdata)
    );

    // Owner store, indexed by frame.
    tlbpt_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (FRAMES)
    ) u_frame_owner (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_fault_fr),
        .i_wdata (r_page),
        .i_raddr (ffr),
        .o_rdata (victim)
    );

    // Result words for the hit and miss paths.
    always_comb begin
        hit_res.physical_address = PA_W'((32'(hit_fr) << OFF_W) | 32'(r_off));
        hit_res.frame_number     = BYTE_W'(32'(hit_fr));
        hit_res.tlb_hit          = 1'b1;
        hit_res.page_fault       = 1'b0;
        hit_res.fetch_page       = '0;
        hit_res.evict_valid      = 1'b0;
        hit_res.evicted_page     = '0;

        miss_res.physical_address = PA_W'((32'(res_fr) << OFF_W) | 32'(r_off));
        miss_res.frame_number     = BYTE_W'(32'(res_fr));
        miss_res.tlb_hit          = 1'b0;
        miss_res.page_fault       = !r_pv;
        miss_res.fetch_page       = r_pv ? '0 : BYTE_W'(32'(r_page));
        miss_res.evict_valid      = evict;
        miss_res.evicted_page     = evict ? BYTE_W'(32'(victim)) : '0;
    end

    // Control state: valid bits, pointers and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid   <= '0;
            r_tlb_next    <= '0;
            r_page_valid  <= '0;
            r_fill        <= '0;
            r_next_frame  <= '0;
            r_frames_full <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.resolve) begin
                // Drop the evicted page from the TLB, then refill the oldest slot.
                if (evict) begin
                    for (int i = 0; i < TLB_ENTRIES; i++) begin
                        if (r_tlb_valid[i] && (r_tlb_page[i] == victim)) begin
                            r_tlb_valid[i] <= 1'b0;
                        end
                    end
                end
                r_tlb_valid[r_tlb_next] <= 1'b1;
                r_tlb_next <= (r_tlb_next == LAST_SLOT) ? '0 : r_tlb_next + SLOT_W'(1);

                // Demand paging on a fault.
                if (!r_pv) begin
                    if (evict) begin
                        r_page_valid[victim] <= 1'b0;
                    end
                    r_page_valid[r_page] <= 1'b1;
                    if (nf2 > r_fill) begin
                        r_fill <= nf2;
                    end
                    r_next_frame  <= wrap2 ? '0 : FRAME_W'(nf2);
                    r_frames_full <= full_now || wrap2;
                end
            end

            // Output word valid.
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_page <= PAGE_W'(32'(i_va) >> OFF_W);
            r_off  <= OFF_W'(i_va);
        end
        if (i_cmd.lookup) begin
            r_pv       <= r_page_valid[r_page];
            r_fault_fr <= ffr;
            r_wrap     <= wrap1;
            if (hit) begin
                r_res <= hit_res;
            end
        end
        if (i_cmd.resolve) begin
            r_res <= miss_res;
            r_tlb_page[r_tlb_next]  <= r_page;
            r_tlb_frame[r_tlb_next] <= res_fr;
        end
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    assign o_status.tlb_hit  = hit;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule

`default_nettype wire

### hdl/tlbpt_checker.sv
// ----------------------------------------------------------------------------
// tlbpt_checker: port-level checks for the translation block
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_checker import tlbpt_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_tlb_hit,
    input wire logic              i_page_fault,
    input wire logic [BYTE_W-1:0] i_fetch_page,
    input wire logic              i_evict_valid,
    input wire logic [BYTE_W-1:0] i_evicted_page
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // One address at a time: no acceptance in the cycle after one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("address accepted while another is in flight");

    // A TLB hit never faults.
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_tlb_hit && i_page_fault))
        else $error("tlb hit reported together with a page fault");

    // Evictions only happen on faults.
    a_evict_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_evict_valid |-> i_page_fault)
        else $error("eviction without a page fault");

    // Page numbers read zero when their flag is clear.
    a_zero_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_page_fault || (i_fetch_page == '0))
                     && (i_evict_valid || (i_evicted_page == '0)))
        else $error("page number set without its flag");

endmodule

bind tlb_page_table_fifo_translate tlbpt_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_va.valid),
    .i_in_ready     (i_va.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_tlb_hit      (o_res.tlb_hit),
    .i_page_fault   (o_res.page_fault),
    .i_fetch_page   (o_res.fetch_page),
    .i_evict_valid  (o_res.evict_valid),
    .i_evicted_page (o_res.evicted_page)
);

`default_nettype wire

### bench/tb_tlb_page_table_fifo_translate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlb_page_table_fifo_translate: self-checking bench for the translator
// Streams virtual addresses through the block under several frame limits and
// checks every result word against a cycle-free predictor of the TLB, the
// page table and the FIFO frame allocator. Both handshake sides idle in
// random bursts, except in the final phase.
// ----------------------------------------------------------------------------

module tb_tlb_page_table_fifo_translate;

    import tlbpt_pkg::*;

    localparam int                    CLK_HALF        = 6;
    localparam int                    MAX_REPORTS     = 10;
    localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // Configuration port.
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tlbpt_va_if  va_bus ();
    tlbpt_res_if res_bus ();

    tlb_page_table_fifo_translate dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_va    (va_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Addresses waiting to be sent and translations waiting to come back.
    logic [VA_W-1:0] pending_va[$];
    t_result         expected_xlat[$];

    int unsigned error_count = 0;
    bit          no_idle     = 1'b0;
    int          send_gap    = 0;
    int          recv_stall  = 0;

    // Predictor state: TLB, page table and frame allocator.
    logic [LIMIT_W-1:0] frame_limit_q;
    bit                 tlb_v     [DEF_TLB_ENTRIES];
    logic [BYTE_W-1:0]  tlb_pg    [DEF_TLB_ENTRIES];
    logic [BYTE_W-1:0]  tlb_fr    [DEF_TLB_ENTRIES];
    int                 tlb_slot;
    bit                 pg_v      [DEF_PAGES];
    logic [BYTE_W-1:0]  pg_fr     [DEF_PAGES];
    logic [BYTE_W-1:0]  fr_owner  [DEF_FRAMES];
    bit                 fr_owned  [DEF_FRAMES];
    int                 alloc_ptr;
    bit                 all_used;

    // Translates one address and advances the predictor state.
    function automatic t_result translate_va(input logic [VA_W-1:0] va);
        t_result           r;
        int                pg;
        int                off;
        int                fr;
        int                lim;
        bit                hit;
        bit                fault;
        bit                evict;
        int                victim;
        pg     = int'((va / DEF_PAGE_BYTES) % DEF_PAGES);
        off    = int'(va % DEF_PAGE_BYTES);
        fr     = 0;
        hit    = 1'b0;
        fault  = 1'b0;
        evict  = 1'b0;
        victim = 0;
        // The lowest matching slot wins.
        for (int i = 0; i < DEF_TLB_ENTRIES; i++) begin
            if (!hit && tlb_v[i] && int'(tlb_pg[i]) == pg) begin
                hit = 1'b1;
                fr  = int'(tlb_fr[i]);
            end
        end
        if (!hit) begin
            if (pg_v[pg]) begin
                fr = int'(pg_fr[pg]);
            end else begin
                // A limit of zero acts as one, anything above the frame count as the count.
                lim = int'(frame_limit_q);
                if (lim < 1) lim = 1;
                if (lim > DEF_FRAMES) lim = DEF_FRAMES;
                fault = 1'b1;
                if (alloc_ptr >= lim) begin
                    alloc_ptr = 0;
                    all_used  = 1'b1;
                end
                fr = alloc_ptr;
                // Reclaim the frame from its owner, if it has one.
                if (all_used && fr_owned[fr]) begin
                    victim       = int'(fr_owner[fr]);
                    evict        = 1'b1;
                    pg_v[victim] = 1'b0;
                    for (int i = 0; i < DEF_TLB_ENTRIES; i++) begin
                        if (tlb_v[i] && int'(tlb_pg[i]) == victim) tlb_v[i] = 1'b0;
                    end
                end
                fr_owner[fr] = BYTE_W'(pg);
                fr_owned[fr] = 1'b1;
                pg_v[pg]     = 1'b1;
                pg_fr[pg]    = BYTE_W'(fr);
                alloc_ptr    = fr + 1;
                if (alloc_ptr >= lim) begin
                    alloc_ptr = 0;
                    all_used  = 1'b1;
                end
            end
            // Strict round-robin refill, holes or not.
            tlb_v[tlb_slot]  = 1'b1;
            tlb_pg[tlb_slot] = BYTE_W'(pg);
            tlb_fr[tlb_slot] = BYTE_W'(fr);
            tlb_slot         = (tlb_slot + 1) % DEF_TLB_ENTRIES;
        end
        r.physical_address = PA_W'(fr * DEF_PAGE_BYTES + off);
        r.frame_number     = BYTE_W'(fr);
        r.tlb_hit          = hit;
        r.page_fault       = fault;
        r.fetch_page       = fault ? BYTE_W'(pg) : '0;
        r.evict_valid      = evict;
        r.evicted_page     = evict ? BYTE_W'(victim) : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            if (error_count < MAX_REPORTS) begin
                $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
                         $realtime, name, want, got);
            end
            error_count++;
        end
    endtask

    // Address driver: predicts each accepted word, then presents the next.
    always @(posedge i_clk) begin : drive_va
        if (i_rst_n && va_bus.valid && va_bus.ready) begin
            expected_xlat.push_back(translate_va(va_bus.virtual_address));
        end
        if (!i_rst_n) begin
            va_bus.valid <= 1'b0;
        end else if (!(va_bus.valid && !va_bus.ready)) begin
            if (send_gap == 0 && !no_idle && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 18);
            end
            if (send_gap > 0) begin
                send_gap--;
                va_bus.valid <= 1'b0;
            end else if (pending_va.size() != 0) begin
                va_bus.valid           <= 1'b1;
                va_bus.virtual_address <= pending_va.pop_front();
            end else begin
                va_bus.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each accepted word with the oldest translation.
    always @(posedge i_clk) begin : watch_res
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_xlat.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("%0t: result word with no translation pending", $realtime);
                end
                error_count++;
            end else begin
                want = expected_xlat.pop_front();
                check_field("physical_address", 32'(want.physical_address),
                            32'(res_bus.physical_address));
                check_field("frame_number", 32'(want.frame_number),
                            32'(res_bus.frame_number));
                check_field("tlb_hit", 32'(want.tlb_hit), 32'(res_bus.tlb_hit));
                check_field("page_fault", 32'(want.page_fault), 32'(res_bus.page_fault));
                check_field("fetch_page", 32'(want.fetch_page), 32'(res_bus.fetch_page));
                check_field("evict_valid", 32'(want.evict_valid),
                            32'(res_bus.evict_valid));
                check_field("evicted_page", 32'(want.evicted_page),
                            32'(res_bus.evicted_page));
            end
        end
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (recv_stall == 0 && !no_idle && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(1, 18);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reads the frame limit back and compares it with the predictor's copy.
    task automatic check_limit();
        logic [APB_DATA_W-1:0] rd;
        apb_read(CFG_FRAME_LIMIT_ADDR, rd);
        check_field("frame_limit", {{(APB_DATA_W-LIMIT_W){1'b0}}, frame_limit_q}, rd);
    endtask

    task automatic set_limit(input logic [APB_DATA_W-1:0] value);
        apb_write(CFG_FRAME_LIMIT_ADDR, value);
        frame_limit_q = value[LIMIT_W-1:0];
        check_limit();
    endtask

    // Waits until every address went out and every translation came back.
    task automatic drain();
        while (pending_va.size() != 0 || va_bus.valid || expected_xlat.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Random addresses, most of them from a small pool of hot pages.
    task automatic queue_random(input int count, input int hot);
        logic [BYTE_W-1:0] pool[24];
        logic [BYTE_W-1:0] pg;
        for (int i = 0; i < 24; i++) pool[i] = BYTE_W'($urandom_range(0, 255));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 70) pg = pool[$urandom_range(0, hot - 1)];
            else pg = BYTE_W'($urandom_range(0, 255));
            pending_va.push_back({pg, BYTE_W'($urandom_range(0, 255))});
        end
    endtask

    initial begin : main
        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        va_bus.valid            = 1'b0;
        va_bus.virtual_address  = '0;
        res_bus.ready           = 1'b0;
        frame_limit_q           = FRAME_LIMIT_RESET;
        tlb_slot                = 0;
        alloc_ptr               = 0;
        all_used                = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset value of the limit, then the field extremes and a TLB wrap.
        check_limit();
        pending_va.push_back(16'h0000);
        pending_va.push_back(16'hFFFF);
        pending_va.push_back(16'h00FF);
        pending_va.push_back(16'hFF00);
        for (int p = 1; p <= 15; p++) pending_va.push_back({BYTE_W'(p), BYTE_W'(p * 17)});
        // Page zero fell out of the TLB but is still resident.
        pending_va.push_back(16'h00AA);
        pending_va.push_back(16'hFF01);
        pending_va.push_back(16'h0F80);
        drain();

        // Limit lowered below the allocation pointer: wrap and reclaim.
        set_limit(32'd2);
        queue_random(120, 5);
        drain();

        // A write to an unused register leaves the limit alone.
        apb_write(UNUSED_REG_ADDR, 32'h0000_0005);
        check_limit();

        // A zero limit acts as a single frame.
        set_limit(32'd0);
        queue_random(80, 4);
        drain();

        // Upper bits are dropped; the raised limit reaches unowned frames while full.
        set_limit(32'hFFFF_FE40);
        queue_random(200, 24);
        drain();

        // A limit above the frame count acts as the frame count.
        set_limit(32'd511);
        queue_random(200, 24);
        drain();

        set_limit(32'd1);
        queue_random(60, 6);
        drain();

        set_limit(32'd256);
        queue_random(200, 20);
        drain();

        // Final phase without idling on either side.
        set_limit($urandom_range(1, 300));
        no_idle = 1'b1;
        queue_random(190, 16);
        drain();
        repeat (20) @(posedge i_clk);

        if (error_count == 0 && expected_xlat.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/tlbpt_pkg.sv
hdl/tlbpt_va_if.sv
hdl/tlbpt_res_if.sv
hdl/tlbpt_ram.sv
hdl/tlbpt_cfg.sv
hdl/tlbpt_ctrl.sv
hdl/tlbpt_dp.sv
hdl/tlb_page_table_fifo_translate.sv
hdl/tlbpt_checker.sv
bench/tb_tlb_page_table_fifo_translate.sv
